// ----- rtl/elf_section_table_end_parser_assert.svh -----
// ----------------------------------------------------------------------------
// elf section table end parser assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ELF_SECTION_TABLE_END_PARSER_ASSERT_SVH
`define ELF_SECTION_TABLE_END_PARSER_ASSERT_SVH

// same-cycle implication
`define ESEC_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// next-cycle implication
`define ESEC_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

// ----- rtl/esec_pkg.sv -----
// ----------------------------------------------------------------------------
// esec_pkg
// types, header layout constants and helpers for the section table end parser
// ----------------------------------------------------------------------------
package esec_pkg;

    // header store limits
    localparam logic [6:0] HDR_MAX  = 7'd64;
    localparam logic [6:0] MIN_LEN  = 7'd24;
    localparam logic [6:0] LEN32    = 7'h34;
    localparam logic [6:0] LEN64    = 7'h40;

    // identification bytes
    localparam logic [7:0] MAGIC0   = 8'h7f;
    localparam logic [7:0] MAGIC1   = 8'h45;
    localparam logic [7:0] MAGIC2   = 8'h4c;
    localparam logic [7:0] MAGIC3   = 8'h46;
    localparam logic [5:0] POS_CLASS = 6'd4;
    localparam logic [5:0] POS_DATA  = 6'd5;
    localparam logic [5:0] MAGIC_LEN = 6'd4;
    localparam logic [7:0] CLASS_32 = 8'd1;
    localparam logic [7:0] CLASS_64 = 8'd2;
    localparam logic [7:0] DATA_BIG = 8'd2;

    // field positions, 64-bit class
    localparam logic [5:0] OFF64_BASE  = 6'h28;
    localparam logic [5:0] SIZE64_BASE = 6'h3a;
    localparam logic [5:0] CNT64_BASE  = 6'h3c;
    // field positions, 32-bit class
    localparam logic [5:0] OFF32_BASE  = 6'h20;
    localparam logic [5:0] SIZE32_BASE = 6'h2e;
    localparam logic [5:0] CNT32_BASE  = 6'h30;

    // field lengths in bytes
    localparam logic [5:0] OFF64_LEN = 6'd8;
    localparam logic [5:0] OFF32_LEN = 6'd4;
    localparam logic [5:0] HALF_LEN  = 6'd2;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        header_valid;
        logic [63:0] table_end_offset;
        logic        wide_class;
        logic        big_endian;
    } t_out_item;

    // classified header, handed from front to back
    typedef struct packed {
        logic        valid;
        logic        wide;
        logic        big;
        logic [63:0] offset;
        logic [15:0] size;
        logic [15:0] count;
    } t_hdr_rec;

    // expected magic byte at position idx
    function automatic logic [7:0] f_magic(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = MAGIC0;
            2'd1:    m = MAGIC1;
            2'd2:    m = MAGIC2;
            default: m = MAGIC3;
        endcase
        return m;
    endfunction

    // true when pos lies in [base, base + len)
    function automatic logic f_in_field(input logic [5:0] pos, input logic [5:0] base,
                                        input logic [5:0] len);
        logic [5:0] d;
        d = pos - base;
        return (pos >= base) && (d < len);
    endfunction

    // byte lane of byte k inside a field whose last index is top
    function automatic logic [2:0] f_lane(input logic [2:0] k, input logic [2:0] top,
                                          input logic big);
        return big ? (top - k) : k;
    endfunction

endpackage

// ----- rtl/esec_front.sv -----
// ----------------------------------------------------------------------------
// esec_front
// takes header bytes, checks magic and class, notes byte order, captures table fields
// ----------------------------------------------------------------------------
module esec_front
    import esec_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_rec_push,
    output t_hdr_rec o_rec
);

    logic [6:0]  r_count, n_count;
    logic        r_magic, n_magic;
    logic [7:0]  r_class, n_class;
    logic        r_big, n_big;
    logic [63:0] r_offset, n_offset;
    logic [15:0] r_size, n_size;
    logic [15:0] r_cnt, n_cnt;

    logic [5:0]  pos;
    logic        keep;
    logic [7:0]  b;
    logic [5:0]  d_off, d_size, d_cnt;
    logic        wide_ok, narrow_ok;

    assign pos  = r_count[5:0];
    assign keep = (r_count < HDR_MAX);
    assign b    = i_item.header_byte;

    // next header state for this byte
    always_comb begin
        n_count  = r_count;
        n_magic  = r_magic;
        n_class  = r_class;
        n_big    = r_big;
        n_offset = r_offset;
        n_size   = r_size;
        n_cnt    = r_cnt;
        d_off    = '0;
        d_size   = '0;
        d_cnt    = '0;
        if (keep) begin
            if ((pos < MAGIC_LEN) && (b != f_magic(pos[1:0]))) begin
                n_magic = 1'b0;
            end
            if (pos == POS_CLASS) begin
                n_class = b;
            end
            if (pos == POS_DATA) begin
                n_big = (b == DATA_BIG);
            end
            // field capture, class and order as seen before this byte
            if (r_class == CLASS_64) begin
                d_off  = pos - OFF64_BASE;
                d_size = pos - SIZE64_BASE;
                d_cnt  = pos - CNT64_BASE;
                if (f_in_field(pos, OFF64_BASE, OFF64_LEN)) begin
                    n_offset[{f_lane(d_off[2:0], 3'd7, r_big), 3'b000} +: 8] = b;
                end
                if (f_in_field(pos, SIZE64_BASE, HALF_LEN)) begin
                    n_size[{f_lane(d_size[2:0], 3'd1, r_big) == 3'd1, 3'b000} +: 8] = b;
                end
                if (f_in_field(pos, CNT64_BASE, HALF_LEN)) begin
                    n_cnt[{f_lane(d_cnt[2:0], 3'd1, r_big) == 3'd1, 3'b000} +: 8] = b;
                end
            end else if (r_class == CLASS_32) begin
                d_off  = pos - OFF32_BASE;
                d_size = pos - SIZE32_BASE;
                d_cnt  = pos - CNT32_BASE;
                if (f_in_field(pos, OFF32_BASE, OFF32_LEN)) begin
                    n_offset[{f_lane(d_off[2:0], 3'd3, r_big), 3'b000} +: 8] = b;
                end
                if (f_in_field(pos, SIZE32_BASE, HALF_LEN)) begin
                    n_size[{f_lane(d_size[2:0], 3'd1, r_big) == 3'd1, 3'b000} +: 8] = b;
                end
                if (f_in_field(pos, CNT32_BASE, HALF_LEN)) begin
                    n_cnt[{f_lane(d_cnt[2:0], 3'd1, r_big) == 3'd1, 3'b000} +: 8] = b;
                end
            end
            n_count = r_count + 7'd1;
        end
    end

    // classification on the marked byte
    assign wide_ok   = (n_class == CLASS_64) && (n_count >= LEN64);
    assign narrow_ok = (n_class == CLASS_32) && (n_count >= LEN32);

    assign o_rec_push   = i_accept && i_item.last_byte;
    assign o_rec.valid  = n_magic && (n_count >= MIN_LEN) && (wide_ok || narrow_ok);
    assign o_rec.wide   = (n_class == CLASS_64);
    assign o_rec.big    = n_big;
    assign o_rec.offset = n_offset;
    assign o_rec.size   = n_size;
    assign o_rec.count  = n_cnt;

    // header state, cleared after each marked byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_rec_push) begin
            r_count  <= '0;
            r_magic  <= 1'b1;
            r_class  <= '0;
            r_big    <= 1'b0;
            r_offset <= '0;
            r_size   <= '0;
            r_cnt    <= '0;
        end else if (i_accept) begin
            r_count  <= n_count;
            r_magic  <= n_magic;
            r_class  <= n_class;
            r_big    <= n_big;
            r_offset <= n_offset;
            r_size   <= n_size;
            r_cnt    <= n_cnt;
        end
    end

`include "elf_section_table_end_parser_assert.svh"

    `ESEC_ASSERT_NOW(a_count_cap, 1'b1, r_count <= HDR_MAX, "byte count above header limit")
    `ESEC_ASSERT_NEXT(a_clear_after_last, o_rec_push, r_count == 7'd0 && r_magic, "state not cleared after marked byte")

endmodule

// ----- rtl/esec_queue.sv -----
// ----------------------------------------------------------------------------
// esec_queue
// short first-in first-out queue of classified headers
// ----------------------------------------------------------------------------
module esec_queue
    import esec_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_hdr_rec i_rec,
    output logic     o_full,
    input  logic     i_pop,
    output t_hdr_rec o_rec,
    output logic     o_empty
);

    t_hdr_rec         r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_used;
    logic             do_push, do_pop;

    assign o_full  = (r_used == (QAW+1)'(QDEPTH));
    assign o_empty = (r_used == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_used <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_used <= r_used + (QAW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_used <= r_used - (QAW+1)'(1);
            end
        end
    end

`include "elf_section_table_end_parser_assert.svh"

    `ESEC_ASSERT_NOW(a_no_overflow, i_push, !o_full, "header pushed into full queue")
    `ESEC_ASSERT_NOW(a_no_underflow, i_pop, !o_empty, "header popped from empty queue")

endmodule

// ----- rtl/esec_back.sv -----
// ----------------------------------------------------------------------------
// esec_back
// computes offset plus size times count, holds the result for the receiver
// ----------------------------------------------------------------------------
module esec_back
    import esec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_hdr_rec  i_rec,
    output logic      o_q_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    // multiply stage
    logic        r_s1_v;
    logic        r_s1_valid, r_s1_wide, r_s1_big;
    logic [63:0] r_s1_offset;
    logic [31:0] r_s1_prod;
    // add stage, also the output register
    logic        r_s2_v;
    t_out_item   r_s2_item;

    logic        s1_ready, s2_ready;

    assign s2_ready = !r_s2_v || i_pop;
    assign s1_ready = !r_s1_v || s2_ready;
    assign o_q_pop  = s1_ready && !i_q_empty;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= !i_q_empty;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    // size times count
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_valid  <= i_rec.valid;
            r_s1_wide   <= i_rec.wide;
            r_s1_big    <= i_rec.big;
            r_s1_offset <= i_rec.offset;
            r_s1_prod   <= 32'(i_rec.size) * 32'(i_rec.count);
        end
    end

    // table end, zero for a rejected header
    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_v) begin
            r_s2_item.header_valid     <= r_s1_valid;
            r_s2_item.table_end_offset <= r_s1_valid ?
                                          (r_s1_offset + {32'd0, r_s1_prod}) : 64'd0;
            r_s2_item.wide_class       <= r_s1_wide;
            r_s2_item.big_endian       <= r_s1_big;
        end
    end

    assign o_empty = !r_s2_v;
    assign o_item  = r_s2_item;

`include "elf_section_table_end_parser_assert.svh"

    `ESEC_ASSERT_NOW(a_invalid_zero, r_s2_v && !r_s2_item.header_valid,
        r_s2_item.table_end_offset == 64'd0, "rejected header with nonzero table end")
    `ESEC_ASSERT_NEXT(a_out_hold, r_s2_v && !i_pop,
        r_s2_v && $stable(r_s2_item), "waiting item changed before pop")

endmodule

// ----- rtl/elf_section_table_end_parser.sv -----
// ----------------------------------------------------------------------------
// elf_section_table_end_parser
// finds where the section header table of an object file header ends
// ----------------------------------------------------------------------------
// Usage: header bytes enter in file order, one item per push, while full is
// low; the final byte of a header carries last_byte. Up to 64 bytes are kept
// per header, later ones are dropped, but a marked one still closes the header.
// Each marked byte yields one item on the output queue: the validity flag,
// the table end (offset plus entry size times count), the class and order.
// Bytes without the mark yield nothing.
// Path: the marked byte's header enters the queue, then the 16x16 multiply
// stage, then the 64-bit add into the output register, where empty goes low.
// Throughput: one byte per cycle while full is low, set by the single front
// capture register; headers may follow back to back.
// A four-entry queue sits between the byte front and the arithmetic back.
// Receiver stall: the output register holds its item until pop; the back
// stops, the queue fills, and full rises once four headers wait in the queue
// with two more held in the back.
// Reset: synchronous; drops all queued headers and the partial header.
// ----------------------------------------------------------------------------
module elf_section_table_end_parser
    import esec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic     accept;
    logic     rec_push;
    t_hdr_rec front_rec;
    t_hdr_rec queue_rec;
    logic     q_full, q_empty, q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    // byte capture and classification
    esec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_rec_push (rec_push),
        .o_rec      (front_rec)
    );

    // decoupling queue
    esec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rec   (queue_rec),
        .o_empty (q_empty)
    );

    // table end arithmetic and output register
    esec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_rec     (queue_rec),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule
